/* hw/rtl/rsa_pkg.sv */
// Shared types, constants and operation codes of the reference-counted slot allocator.
package rsa_pkg;

    // Pool geometry
    localparam int NUM_SLOTS  = 2048;
    localparam int COUNT_BITS = 16;
    localparam int SLOT_W     = 11;
    localparam int SLOT_AW    = $clog2(NUM_SLOTS);
    localparam int ROW_W      = 32;
    localparam int ROW_IW     = $clog2(ROW_W);
    localparam int NUM_ROWS   = NUM_SLOTS / ROW_W;
    localparam int ROW_AW     = $clog2(NUM_ROWS);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // Operation codes
    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_GET   = 2'd1;
    localparam logic [1:0] FUNC_PUT   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_NOT_IN_USE = 2'd2;
    localparam logic [1:0] ST_SATURATED  = 2'd3;

    typedef struct packed {
        logic [1:0]        func;
        logic [SLOT_W-1:0] slot_index;
    } in_t;

    typedef struct packed {
        logic [SLOT_W-1:0] granted_slot;
        logic [1:0]        status;
        logic              released;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic upd;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

/* hw/rtl/refcounted_slot_allocator.sv */
// An accepted request word passes through a table read state and an update state before m_valid;
// the update waits while a pending result is not taken. No new request is taken until the update is
// done; the count table and bitmap row memories are each read once and written at most once per request.
// A pending result is held in an output register while the next request is accepted.
// Reset: synchronous, active low; all slots free at once through per-row flags,
// with no clearing pass.
module refcounted_slot_allocator (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rsa_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rsa_pkg::out_t m_data
);

    rsa_pkg::cmd_t cmd;
    rsa_pkg::sts_t sts;

    rsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rsa_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* hw/rtl/rsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/rsa_ctrl.sv */
// Controller state machine: sequences accept, table read and update of one word.
module rsa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rsa_pkg::sts_t sts,
    output rsa_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_READ;
                    ready_next = 1'b0;
                end
            end
            S_READ: begin
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                    ready_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    // Hold state and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    // Drive commands
    assign s_ready  = ready_reg;
    assign cmd.load = s_valid && ready_reg;
    assign cmd.rd   = (state_reg == S_READ);
    assign cmd.upd  = (state_reg == S_UPDATE) && sts.out_free;

    a_load_to_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == S_READ)
        else $error("accepted word did not start a table read");

    a_read_to_update: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_READ |=> state_reg == S_UPDATE && !ready_reg)
        else $error("table read not followed by update");

    a_upd_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.upd |=> state_reg == S_IDLE && ready_reg)
        else $error("update did not return to idle");

endmodule

/* hw/rtl/rsa_dp.sv */
// Datapath: in-use bitmap rows, row summary flags, count table and result register.
module rsa_dp (
    input  logic          aclk,
    input  logic          aresetn,
    input  rsa_pkg::in_t  s_data,
    input  rsa_pkg::cmd_t cmd,
    output rsa_pkg::sts_t sts,
    output logic          m_valid,
    input  logic          m_ready,
    output rsa_pkg::out_t m_data
);

    logic [1:0]                      func_reg;
    logic [rsa_pkg::SLOT_W-1:0]      idx_reg;
    logic [rsa_pkg::ROW_AW-1:0]      alloc_row_reg, alloc_row_next;
    logic                            any_free_reg;
    logic [rsa_pkg::NUM_ROWS-1:0]    row_valid_reg;
    logic [rsa_pkg::NUM_ROWS-1:0]    row_full_reg;
    logic [rsa_pkg::NUM_ROWS-1:0]    free_rows, free_row_low;
    logic                            out_valid_reg;
    rsa_pkg::out_t                   out_reg, out_next;

    logic [rsa_pkg::ROW_AW-1:0]      row_sel;
    logic [rsa_pkg::ROW_W-1:0]       map_rdata, row_word, free_bits, free_bit_low;
    logic [rsa_pkg::ROW_W-1:0]       map_wdata;
    logic                            map_we;
    logic [rsa_pkg::ROW_IW-1:0]      alloc_bit;
    logic                            slot_bit, in_range;
    logic [rsa_pkg::COUNT_BITS-1:0]  cnt_rdata, cnt_wdata;
    logic                            cnt_we;
    logic [rsa_pkg::SLOT_AW-1:0]     cnt_waddr;

    // Lowest row that still has a free slot
    always_comb begin
        free_rows      = ~row_full_reg;
        free_row_low   = free_rows & (~free_rows + rsa_pkg::NUM_ROWS'(1));
        alloc_row_next = '0;
        for (int i = 0; i < rsa_pkg::NUM_ROWS; i++) begin
            if (free_row_low[i]) begin
                alloc_row_next = alloc_row_next | rsa_pkg::ROW_AW'(i);
            end
        end
    end

    // Capture the request word
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg      <= s_data.func;
            idx_reg       <= s_data.slot_index;
            alloc_row_reg <= alloc_row_next;
            any_free_reg  <= |free_rows;
        end
    end

    // Row addressed by this request
    assign row_sel = (func_reg == rsa_pkg::FUNC_ALLOC) ? alloc_row_reg
                   : idx_reg[rsa_pkg::SLOT_AW-1:rsa_pkg::ROW_IW];

    // Count entry written by this request: the claimed slot for an allocate
    assign cnt_waddr = (func_reg == rsa_pkg::FUNC_ALLOC) ? {alloc_row_reg, alloc_bit}
                     : idx_reg[rsa_pkg::SLOT_AW-1:0];

    rsa_ram #(
        .WIDTH (rsa_pkg::ROW_W),
        .DEPTH (rsa_pkg::NUM_ROWS)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (map_we && cmd.upd),
        .waddr (row_sel),
        .wdata (map_wdata),
        .re    (cmd.rd),
        .raddr (row_sel),
        .rdata (map_rdata)
    );

    rsa_ram #(
        .WIDTH (rsa_pkg::COUNT_BITS),
        .DEPTH (rsa_pkg::NUM_SLOTS)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we && cmd.upd),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cmd.rd),
        .raddr (idx_reg[rsa_pkg::SLOT_AW-1:0]),
        .rdata (cnt_rdata)
    );

    // Rows never written since reset read as all free
    always_comb begin
        row_word     = row_valid_reg[row_sel] ? map_rdata : '0;
        free_bits    = ~row_word;
        free_bit_low = free_bits & (~free_bits + rsa_pkg::ROW_W'(1));
        alloc_bit    = '0;
        for (int i = 0; i < rsa_pkg::ROW_W; i++) begin
            if (free_bit_low[i]) begin
                alloc_bit = alloc_bit | rsa_pkg::ROW_IW'(i);
            end
        end
        slot_bit = row_word[idx_reg[rsa_pkg::ROW_IW-1:0]];
        in_range = int'(idx_reg) < rsa_pkg::NUM_SLOTS;
    end

    // Decide the operation and build the result
    always_comb begin
        map_we                = 1'b0;
        map_wdata             = row_word;
        cnt_we                = 1'b0;
        cnt_wdata             = cnt_rdata;
        out_next.granted_slot = idx_reg;
        out_next.status       = rsa_pkg::ST_OK;
        out_next.released     = 1'b0;
        unique case (func_reg)
            rsa_pkg::FUNC_ALLOC: begin
                out_next.granted_slot = '0;
                if (!any_free_reg) begin
                    out_next.status = rsa_pkg::ST_FULL;
                end else begin
                    out_next.granted_slot = rsa_pkg::SLOT_W'({alloc_row_reg, alloc_bit});
                    map_wdata             = row_word | free_bit_low;
                    map_we                = 1'b1;
                    cnt_wdata             = rsa_pkg::COUNT_ONE;
                    cnt_we                = 1'b1;
                end
            end
            rsa_pkg::FUNC_GET: begin
                if (!in_range || !slot_bit) begin
                    out_next.status = rsa_pkg::ST_NOT_IN_USE;
                end else if (cnt_rdata == rsa_pkg::COUNT_MAX) begin
                    out_next.status = rsa_pkg::ST_SATURATED;
                end else begin
                    cnt_wdata = cnt_rdata + rsa_pkg::COUNT_ONE;
                    cnt_we    = 1'b1;
                end
            end
            rsa_pkg::FUNC_PUT: begin
                if (!in_range || !slot_bit) begin
                    out_next.status = rsa_pkg::ST_NOT_IN_USE;
                end else if (cnt_rdata <= rsa_pkg::COUNT_ONE) begin
                    // last reference: free the slot, its count is dead until reused
                    map_wdata = row_word
                              & ~(rsa_pkg::ROW_W'(1) << idx_reg[rsa_pkg::ROW_IW-1:0]);
                    map_we            = 1'b1;
                    out_next.released = 1'b1;
                end else begin
                    cnt_wdata = cnt_rdata - rsa_pkg::COUNT_ONE;
                    cnt_we    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Track row summary flags and the result word's valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            row_full_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.upd && map_we) begin
                row_valid_reg[row_sel] <= 1'b1;
                row_full_reg[row_sel]  <= &map_wdata;
            end
            if (cmd.upd) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result word
    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            out_reg <= out_next;
        end
    end

    assign sts.out_free = !out_valid_reg || m_ready;
    assign m_valid      = out_valid_reg;
    assign m_data       = out_reg;

    a_upd_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.upd |-> !out_valid_reg || m_ready)
        else $error("result overwritten while still pending");

    a_full_implies_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_full_reg & ~row_valid_reg) == '0)
        else $error("row marked full but never written");

    a_alloc_marks_row: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.upd && func_reg == rsa_pkg::FUNC_ALLOC && any_free_reg
        |=> row_valid_reg[$past(alloc_row_reg)])
        else $error("granted row not marked written");

    a_alloc_had_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.upd && func_reg == rsa_pkg::FUNC_ALLOC && any_free_reg |-> !(&row_word))
        else $error("allocation row has no free slot");

endmodule

/* dv/tb_refcounted_slot_allocator.sv */
// Self-checking testbench for the reference-counted slot allocator: random handshakes, shadow pool.
module tb_refcounted_slot_allocator;

    // Opcode that the block treats as a no-op
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_STEP    = 67_800;
    localparam int RANDOM_REQS  = 1035;
    localparam int WINDOW_TOP   = 63;

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    rsa_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    rsa_pkg::out_t m_data;

    refcounted_slot_allocator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Request words waiting to be driven, and replies owed by the block
    rsa_pkg::in_t  pending_reqs[$];
    rsa_pkg::out_t awaited_replies[$];

    // Shadow pool
    bit                             slot_live [rsa_pkg::NUM_SLOTS];
    logic [rsa_pkg::COUNT_BITS-1:0] slot_refs [rsa_pkg::NUM_SLOTS];

    logic req_taken = 1'b0;
    int   fail_count = 0;
    int   reply_count = 0;
    int   cycle_count = 0;
    int   release_count = 0;
    int   status_seen [4];

    int send_idle = 0;
    int send_phase_left = 0;
    bit send_calm = 1'b0;
    int hold_left = 0;
    int stall_left = 0;
    int recv_phase_left = 0;
    bit recv_calm = 1'b0;
    int next_hold_at = 200;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        else if (r < 90) return $urandom_range(1, 3);
        else if (r < 98) return $urandom_range(4, 12);
        else return $urandom_range(20, 60);
    endfunction

    // Apply one request to the shadow pool and return the reply it owes
    function automatic rsa_pkg::out_t compute_reply(input rsa_pkg::in_t req);
        rsa_pkg::out_t res;
        int            idx;
        int            i;
        bit            found;
        idx = int'(req.slot_index);
        found = 1'b0;
        res.granted_slot = req.slot_index;
        res.status       = rsa_pkg::ST_OK;
        res.released     = 1'b0;
        unique case (req.func)
            rsa_pkg::FUNC_ALLOC: begin
                // claim the lowest free slot
                res.granted_slot = '0;
                res.status       = rsa_pkg::ST_FULL;
                for (i = 0; i < rsa_pkg::NUM_SLOTS && !found; i++) begin
                    if (!slot_live[i]) begin
                        slot_live[i]     = 1'b1;
                        slot_refs[i]     = rsa_pkg::COUNT_ONE;
                        res.granted_slot = rsa_pkg::SLOT_W'(i);
                        res.status       = rsa_pkg::ST_OK;
                        found            = 1'b1;
                    end
                end
            end
            rsa_pkg::FUNC_GET: begin
                if (idx >= rsa_pkg::NUM_SLOTS || !slot_live[idx]) begin
                    res.status = rsa_pkg::ST_NOT_IN_USE;
                end else if (slot_refs[idx] == rsa_pkg::COUNT_MAX) begin
                    res.status = rsa_pkg::ST_SATURATED;
                end else begin
                    slot_refs[idx] = slot_refs[idx] + rsa_pkg::COUNT_ONE;
                end
            end
            rsa_pkg::FUNC_PUT: begin
                if (idx >= rsa_pkg::NUM_SLOTS || !slot_live[idx]) begin
                    res.status = rsa_pkg::ST_NOT_IN_USE;
                end else if (slot_refs[idx] <= rsa_pkg::COUNT_ONE) begin
                    // last reference gone: free the slot
                    slot_refs[idx] = '0;
                    slot_live[idx] = 1'b0;
                    res.released   = 1'b1;
                end else begin
                    slot_refs[idx] = slot_refs[idx] - rsa_pkg::COUNT_ONE;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic queue_req(input logic [1:0] func, input int slot);
        rsa_pkg::in_t req;
        req.func       = func;
        req.slot_index = rsa_pkg::SLOT_W'(slot);
        pending_reqs.push_back(req);
    endtask

    // Random traffic, mostly aimed at a small window of low slots where
    // releases and reallocation happen, with the odd word anywhere in the pool
    task automatic queue_random_reqs(input int count);
        int         n;
        int         r;
        int         s;
        int         slot;
        logic [1:0] func;
        for (n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, 99);
            if (r < 30) func = rsa_pkg::FUNC_ALLOC;
            else if (r < 60) func = rsa_pkg::FUNC_GET;
            else if (r < 95) func = rsa_pkg::FUNC_PUT;
            else func = FUNC_NONE;
            if (func == rsa_pkg::FUNC_ALLOC || s >= 90) begin
                slot = $urandom_range(0, rsa_pkg::NUM_SLOTS - 1);
            end else if (s < 80) begin
                slot = $urandom_range(1, WINDOW_TOP);
            end else begin
                slot = $urandom_range(rsa_pkg::NUM_SLOTS - 64, rsa_pkg::NUM_SLOTS - 1);
            end
            queue_req(func, slot);
        end
    endtask

    // Drive request words at the falling edge; outside calm phases draw a gap after each one
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || req_taken)) begin
            if (send_idle > 0) begin
                send_idle--;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                s_data  <= pending_reqs.pop_front();
                s_valid <= 1'b1;
                if (send_phase_left == 0) begin
                    send_calm       = !send_calm;
                    send_phase_left = $urandom_range(20, 200);
                end
                send_phase_left--;
                send_idle = send_calm ? 0 : draw_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Drive m_ready: random stalls, plus a single long hold-off once 200 replies are in
    always @(negedge aclk) begin
        if (aresetn) begin
            if (reply_count >= next_hold_at) begin
                next_hold_at += HOLD_STEP;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (recv_phase_left == 0) begin
                    recv_calm       = !recv_calm;
                    recv_phase_left = $urandom_range(50, 600);
                end
                recv_phase_left--;
                if (!recv_calm && $urandom_range(0, 3) == 0) stall_left = draw_gap();
            end
        end
    end

    // Check replies against the oldest expectation, then predict accepted requests
    always @(posedge aclk) begin
        rsa_pkg::out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    $error("unexpected reply word: granted_slot %0d status %0d released %0d",
                           m_data.granted_slot, m_data.status, m_data.released);
                    fail_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (m_data.granted_slot !== want.granted_slot) begin
                        $error("granted_slot mismatch: expected %0d, got %0d",
                               want.granted_slot, m_data.granted_slot);
                        fail_count++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, m_data.status);
                        fail_count++;
                    end
                    if (m_data.released !== want.released) begin
                        $error("released mismatch: expected %0d, got %0d",
                               want.released, m_data.released);
                        fail_count++;
                    end
                    reply_count++;
                    status_seen[want.status]++;
                    release_count += want.released;
                end
            end
            if (s_valid && s_ready) awaited_replies.push_back(compute_reply(s_data));
        end
        req_taken <= aresetn && s_valid && s_ready;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("refcounted_slot_allocator test failed");
            $finish;
        end
    end

    initial begin
        int i;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        for (i = 0; i < rsa_pkg::NUM_SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_refs[i] = '0;
        end
        for (i = 0; i < 4; i++) status_seen[i] = 0;

        // Directed: free-slot rejects, allocate order, release, no-op codes
        queue_req(rsa_pkg::FUNC_GET, 0);
        queue_req(rsa_pkg::FUNC_PUT, rsa_pkg::NUM_SLOTS - 1);
        queue_req(rsa_pkg::FUNC_ALLOC, 0);
        queue_req(rsa_pkg::FUNC_ALLOC, 0);
        queue_req(rsa_pkg::FUNC_GET, 1);
        queue_req(rsa_pkg::FUNC_PUT, 1);
        queue_req(rsa_pkg::FUNC_PUT, 1);
        queue_req(rsa_pkg::FUNC_PUT, 1);
        queue_req(FUNC_NONE, rsa_pkg::NUM_SLOTS - 1);
        queue_req(FUNC_NONE, 'h555);
        queue_req(rsa_pkg::FUNC_ALLOC, 'h7FF);
        queue_req(rsa_pkg::FUNC_ALLOC, rsa_pkg::NUM_SLOTS - 1);
        queue_req(rsa_pkg::FUNC_PUT, 0);
        queue_req(rsa_pkg::FUNC_ALLOC, 0);
        queue_req(rsa_pkg::FUNC_GET, 'h2AA);

        queue_random_reqs(RANDOM_REQS);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Drain: all words sent, all replies in, then let the pipeline settle
        while (pending_reqs.size() > 0 || s_valid) @(posedge aclk);
        while (awaited_replies.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("checked %0d replies in %0d cycles, %0d slot releases",
                 reply_count, cycle_count, release_count);
        $display("status mix: ok %0d, pool full %0d, not in use %0d, saturated %0d",
                 status_seen[rsa_pkg::ST_OK], status_seen[rsa_pkg::ST_FULL],
                 status_seen[rsa_pkg::ST_NOT_IN_USE], status_seen[rsa_pkg::ST_SATURATED]);
        if (fail_count == 0) begin
            $display("refcounted_slot_allocator test passed");
        end else begin
            $display("refcounted_slot_allocator test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/rsa_pkg.sv
hw/rtl/rsa_ram.sv
hw/rtl/rsa_ctrl.sv
hw/rtl/rsa_dp.sv
hw/rtl/refcounted_slot_allocator.sv
dv/tb_refcounted_slot_allocator.sv
